### src/rsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rsc_pkg;
    localparam int DIM_WIDTH = 20;
    localparam int EXT_WIDTH = 21;
    localparam int STRIDE_WIDTH = 40;
    localparam int OFF_WIDTH = 48;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 40;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_COLUMNS = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SOURCE_ROWS = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_PLANES = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_BATCHES = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DEST_ROWS = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW_STRIDE = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_PLANE_STRIDE = 3'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_BATCH_STRIDE = 3'd7;

    typedef struct packed {
        logic [DIM_WIDTH-1:0] column;
        logic [DIM_WIDTH-1:0] plane;
        logic [DIM_WIDTH-1:0] batch;
        logic                 last;
    } pos_t;

    // counter + 1 >= extent, extent clamped to [1, 2^DIM_WIDTH]
    function automatic logic at_last(input logic [DIM_WIDTH-1:0] cnt,
                                     input logic [EXT_WIDTH-1:0] ext);
        logic [EXT_WIDTH:0] lim;
        logic [EXT_WIDTH:0] nxt;
        begin
            lim = {1'b0, ext};
            if (ext == '0)
                lim = 'd1;
            else if (ext > (EXT_WIDTH+1)'(1 << DIM_WIDTH))
                lim = (EXT_WIDTH+1)'(1 << DIM_WIDTH);
            nxt = (EXT_WIDTH+1)'(cnt) + 1'b1;
            at_last = (nxt >= lim);
        end
    endfunction
endpackage
`default_nettype wire

### src/rsc_counters.sv
`timescale 1ns / 1ps
`default_nettype none
module rsc_counters
    import rsc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire logic [EXT_WIDTH-1:0] columns,
    input  wire logic [EXT_WIDTH-1:0] source_rows,
    input  wire logic [EXT_WIDTH-1:0] planes,
    input  wire logic [EXT_WIDTH-1:0] batches,
    output pos_t                      pos
);
    logic [DIM_WIDTH-1:0] col_reg, row_reg, pln_reg, bat_reg;
    logic lc, lr, lp, lb;

    assign lc = at_last(col_reg, columns);
    assign lr = at_last(row_reg, source_rows);
    assign lp = at_last(pln_reg, planes);
    assign lb = at_last(bat_reg, batches);

    assign pos.column = col_reg;
    assign pos.plane  = pln_reg;
    assign pos.batch  = bat_reg;
    assign pos.last   = lc & lr & lp & lb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            pln_reg <= '0;
            bat_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= lc ? '0 : col_reg + 1'b1;
            if (lc)
                row_reg <= lr ? '0 : row_reg + 1'b1;
            if (lc && lr)
                pln_reg <= lp ? '0 : pln_reg + 1'b1;
            if (lc && lr && lp)
                bat_reg <= lb ? '0 : bat_reg + 1'b1;
        end
    end
endmodule
`default_nettype wire

### src/rsc_f16_conv.sv
`timescale 1ns / 1ps
`default_nettype none
module rsc_f16_conv
    import rsc_pkg::*;
(
    input  wire logic [31:0] value_bits,
    output logic      [15:0] half
);
    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [23:0] mant;
    logic [4:0]  shift;
    logic [23:0] q, rem, halfway, mask;
    logic [15:0] h;
    logic [12:0] r13;

    always_comb
    begin
        sgn = value_bits[31];
        ex = value_bits[30:23];
        man = value_bits[22:0];
        mant = {1'b1, man};
        shift = '0;
        q = '0;
        rem = '0;
        halfway = '0;
        mask = '0;
        h = '0;
        r13 = man[12:0];
        if (ex == 8'hFF)
            half = (man != '0) ? {sgn, 5'h1F, 1'b1, man[21:13]} : {sgn, 15'h7C00};
        else if (ex >= 8'd143)
            half = {sgn, 15'h7C00};
        else if (ex <= 8'd112)
        begin
            // shift = 14 - (ex - 112) = 126 - ex
            if (ex == 8'd0 || ex < 8'd102)
                half = {sgn, 15'h0};
            else
            begin
                shift = 5'(8'd126 - ex);
                q = mant >> shift;
                mask = (24'd1 << shift) - 24'd1;
                rem = mant & mask;
                halfway = 24'd1 << (shift - 5'd1);
                if (rem > halfway || (rem == halfway && q[0]))
                    q = q + 24'd1;
                half = {sgn, q[14:0]};
            end
        end
        else
        begin
            h = {1'b0, 5'(ex - 8'd112), man[22:13]};
            if (r13 > 13'h1000 || (r13 == 13'h1000 && h[0]))
                h = h + 16'd1;
            half = {sgn, h[14:0]};
        end
    end
endmodule
`default_nettype wire

### src/row_scatter_f32_to_f16_top.sv
// Path: accepted request -> stage 1 input reg -> stage 2 result reg -> result valid.
// Throughput: one request per cycle absent a stall; stage 1 registers the request,
// position and three stride products, stage 2 sums them and converts the value.
// Reset (rst_n, async, low): counters to zero, extents and dest_rows to 1,
// strides to 0, pipeline empty.
`timescale 1ns / 1ps
`default_nettype none
module row_scatter_f32_to_f16_top
    import rsc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0] cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [31:0]               value_bits,
    input  wire logic signed [63:0]        row_index,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [OFF_WIDTH-1:0]           dest_offset,
    output logic [15:0]                    half_bits,
    output logic                           write_enable,
    output logic                           end_of_tensor
);
    logic [EXT_WIDTH-1:0]    columns_reg, source_rows_reg, planes_reg, batches_reg;
    logic [EXT_WIDTH-1:0]    dest_rows_reg;
    logic [STRIDE_WIDTH-1:0] rstride_reg, pstride_reg, bstride_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg     <= 'd1;
            source_rows_reg <= 'd1;
            planes_reg      <= 'd1;
            batches_reg     <= 'd1;
            dest_rows_reg   <= 'd1;
            rstride_reg     <= '0;
            pstride_reg     <= '0;
            bstride_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COLUMNS:      columns_reg     <= cfg_data[EXT_WIDTH-1:0];
                REG_SOURCE_ROWS:  source_rows_reg <= cfg_data[EXT_WIDTH-1:0];
                REG_PLANES:       planes_reg      <= cfg_data[EXT_WIDTH-1:0];
                REG_BATCHES:      batches_reg     <= cfg_data[EXT_WIDTH-1:0];
                REG_DEST_ROWS:    dest_rows_reg   <= cfg_data[EXT_WIDTH-1:0];
                REG_ROW_STRIDE:   rstride_reg     <= cfg_data;
                REG_PLANE_STRIDE: pstride_reg     <= cfg_data;
                REG_BATCH_STRIDE: bstride_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline: stage 1 (s1) holds products, stage 2 (s2) is the result register.
    logic s1_valid_reg, s2_valid_reg;
    logic s1_ready, s2_load;
    assign s2_load  = s1_valid_reg && (!s2_valid_reg || out_ready);
    assign s1_ready = !s1_valid_reg || s2_load;
    assign in_ready = s1_ready;

    logic accept;
    assign accept = in_valid && in_ready;

    pos_t pos;
    rsc_counters u_cnt (
        .clk(clk), .rst_n(rst_n), .advance(accept),
        .columns(columns_reg), .source_rows(source_rows_reg),
        .planes(planes_reg), .batches(batches_reg), .pos(pos)
    );

    // Row check: non-negative and below dest_rows. In range means row fits 21 bits.
    logic we_in;
    assign we_in = !row_index[63] && (row_index[62:EXT_WIDTH] == '0)
                   && (row_index[EXT_WIDTH-1:0] < dest_rows_reg);

    // Offset is mod 2^48; only the low bits of row matter, and in range row < 2^21.
    // Operands are widened first so the products keep all 48 offset bits.
    logic [OFF_WIDTH-1:0] prow_next, ppln_next, pbat_next;
    assign prow_next = OFF_WIDTH'(row_index[EXT_WIDTH-1:0]) * OFF_WIDTH'(rstride_reg);
    assign ppln_next = OFF_WIDTH'(pos.plane) * OFF_WIDTH'(pstride_reg);
    assign pbat_next = OFF_WIDTH'(pos.batch) * OFF_WIDTH'(bstride_reg);

    logic [OFF_WIDTH-1:0] prow_reg, ppln_reg, pbat_reg;
    logic [DIM_WIDTH-1:0] col_reg;
    logic [31:0]          val_reg;
    logic                 we_reg, last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prow_reg <= prow_next;
            ppln_reg <= ppln_next;
            pbat_reg <= pbat_next;
            col_reg  <= pos.column;
            val_reg  <= value_bits;
            we_reg   <= we_in;
            last_reg <= pos.last;
        end
    end

    logic [15:0] half_conv;
    rsc_f16_conv u_conv (.value_bits(val_reg), .half(half_conv));

    logic [OFF_WIDTH-1:0] off_next;
    assign off_next = OFF_WIDTH'({col_reg, 1'b0}) + prow_reg + ppln_reg + pbat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_load)
            s2_valid_reg <= 1'b1;
        else if (out_ready)
            s2_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            dest_offset   <= we_reg ? off_next : '0;
            half_bits     <= we_reg ? half_conv : '0;
            write_enable  <= we_reg;
            end_of_tensor <= last_reg;
        end
    end

    assign out_valid = s2_valid_reg;
endmodule
`default_nettype wire
